// File: rtl/stt_pkg.sv
package stt_pkg;

    localparam int PositionBitsDef = 16;
    localparam int LengthBitsDef   = 12;
    localparam int KeywordMaxDef   = 10;
    localparam int KwChars         = 10;
    localparam int KwCount         = 17;
    localparam int FifoDepth       = 8;
    localparam int FifoAw          = 3;
    localparam int MaxResults      = 3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_present;
        logic       source_end;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [2:0]  error_code;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [11:0] token_length;
        logic        run_last;
    } t_out_item;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_SLASH,
        M_LINECOM, M_BLOCKCOM, M_COLON, M_LESS, M_GREATER
    } t_mode;

    localparam logic [5:0] K_END    = 6'd0;
    localparam logic [5:0] K_ID     = 6'd1;
    localparam logic [5:0] K_NUM    = 6'd2;
    localparam logic [5:0] K_STR    = 6'd3;
    localparam logic [5:0] K_KW0    = 6'd4;
    localparam logic [5:0] K_PLUS   = 6'd21;
    localparam logic [5:0] K_MINUS  = 6'd22;
    localparam logic [5:0] K_MULT   = 6'd23;
    localparam logic [5:0] K_DIV    = 6'd24;
    localparam logic [5:0] K_EQ     = 6'd25;
    localparam logic [5:0] K_NE     = 6'd26;
    localparam logic [5:0] K_LT     = 6'd27;
    localparam logic [5:0] K_LE     = 6'd28;
    localparam logic [5:0] K_GT     = 6'd29;
    localparam logic [5:0] K_GE     = 6'd30;
    localparam logic [5:0] K_ASSIGN = 6'd31;
    localparam logic [5:0] K_SEMI   = 6'd32;
    localparam logic [5:0] K_DOT    = 6'd33;
    localparam logic [5:0] K_COMMA  = 6'd34;
    localparam logic [5:0] K_COLON  = 6'd35;
    localparam logic [5:0] K_LPAREN = 6'd36;
    localparam logic [5:0] K_RPAREN = 6'd37;
    localparam logic [5:0] K_ERROR  = 6'd38;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_UNKNOWN  = 3'd1;
    localparam logic [2:0] E_STR_NL   = 3'd2;
    localparam logic [2:0] E_STR_OPEN = 3'd3;
    localparam logic [2:0] E_COM_OPEN = 3'd4;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    // keyword text, first char in the top byte, zero padded
    function automatic logic [8*KwChars-1:0] kw_text(input logic [4:0] i);
        logic [8*KwChars-1:0] t;
        unique case (i)
            5'd0:  t = {"programa", 16'h0};
            5'd1:  t = {"var", 56'h0};
            5'd2:  t = {"inteiro", 24'h0};
            5'd3:  t = {"logico", 32'h0};
            5'd4:  t = {"inicio", 32'h0};
            5'd5:  t = {"fim", 56'h0};
            5'd6:  t = {"se", 64'h0};
            5'd7:  t = {"entao", 40'h0};
            5'd8:  t = {"senao", 40'h0};
            5'd9:  t = {"enquanto", 16'h0};
            5'd10: t = {"faca", 48'h0};
            5'd11: t = {"ler", 56'h0};
            5'd12: t = {"escrever", 16'h0};
            5'd13: t = "verdadeiro";
            5'd14: t = {"falso", 40'h0};
            5'd15: t = {"e", 72'h0};
            5'd16: t = {"ou", 64'h0};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [4:0] kw_len(input logic [4:0] i);
        logic [4:0] n;
        unique case (i)
            5'd0, 5'd9, 5'd12:      n = 5'd8;
            5'd1, 5'd5, 5'd11:      n = 5'd3;
            5'd2:                   n = 5'd7;
            5'd3, 5'd4:             n = 5'd6;
            5'd6, 5'd16:            n = 5'd2;
            5'd7, 5'd8, 5'd14:      n = 5'd5;
            5'd10:                  n = 5'd4;
            5'd13:                  n = 5'd10;
            5'd15:                  n = 5'd1;
            default:                n = 5'd0;
        endcase
        return n;
    endfunction

    // w holds the word, first char in the top byte
    function automatic logic [5:0] kw_lookup(input logic [8*KwChars-1:0] w,
                                             input logic [4:0] n);
        logic [5:0]           k;
        logic [8*KwChars-1:0] m;
        k = K_ID;
        for (int i = KwCount - 1; i >= 0; i--) begin
            m = ~({(8*KwChars){1'b1}} >> (8 * kw_len(5'(i))));
            if (kw_len(5'(i)) == n && (w & m) == kw_text(5'(i)))
                k = K_KW0 + 6'(i);
        end
        return k;
    endfunction

endpackage

// File: rtl/stt_core.sv
module stt_core #(
    parameter int POSITION_BITS   = stt_pkg::PositionBitsDef,
    parameter int LENGTH_BITS     = stt_pkg::LengthBitsDef,
    parameter int KEYWORD_MAX_LEN = stt_pkg::KeywordMaxDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  stt_pkg::t_in_item i_item,
    output stt_pkg::t_out_item o_res [stt_pkg::MaxResults],
    output logic [1:0]        o_res_cnt
);
    localparam int PB = POSITION_BITS;
    localparam int LB = LENGTH_BITS;
    localparam logic [PB-1:0] PosMax = '1;
    localparam logic [LB-1:0] LenMax = '1;

    stt_pkg::t_mode  r_mode, n_mode;
    logic [PB-1:0]   r_line, n_line, r_col, n_col, r_tsl, n_tsl, r_tsc, n_tsc;
    logic [LB-1:0]   r_cnt, n_cnt;
    logic            r_halt, n_halt;
    logic [7:0]      r_buf [KEYWORD_MAX_LEN];
    logic [7:0]      n_buf [KEYWORD_MAX_LEN];

    stt_pkg::t_out_item res [stt_pkg::MaxResults];
    logic [1:0]      rc;
    logic            redo;
    logic [7:0]      b;
    logic            nl;
    logic [PB-1:0]   adv_line, adv_col;
    logic [5:0]      single;

    function automatic logic [PB-1:0] pos_inc(input logic [PB-1:0] v);
        return (v < PosMax) ? v + PB'(1) : PosMax;
    endfunction

    function automatic logic [LB-1:0] len_inc(input logic [LB-1:0] v);
        return (v < LenMax) ? v + LB'(1) : LenMax;
    endfunction

    function automatic stt_pkg::t_out_item mk(input logic [5:0] kind,
                                              input logic [2:0] err,
                                              input logic [PB-1:0] ln,
                                              input logic [PB-1:0] col,
                                              input logic [LB-1:0] len);
        stt_pkg::t_out_item o;
        o.token_kind   = kind;
        o.error_code   = err;
        o.start_line   = 16'(ln);
        o.start_column = 16'(col);
        o.token_length = 12'(len);
        o.run_last     = 1'b0;
        return o;
    endfunction

    function automatic logic [5:0] word_kind(input logic [7:0] wb [KEYWORD_MAX_LEN],
                                             input logic [LB-1:0] n);
        logic [8*stt_pkg::KwChars-1:0] w;
        logic [5:0]                    k;
        for (int i = 0; i < stt_pkg::KwChars; i++)
            w[8*(stt_pkg::KwChars-1-i) +: 8] = wb[i];
        k = stt_pkg::K_ID;
        if (n < LenMax && 32'(n) <= KEYWORD_MAX_LEN)
            k = stt_pkg::kw_lookup(w, 5'(n));
        return k;
    endfunction

    always_comb begin
        n_mode = r_mode;
        n_line = r_line;
        n_col  = r_col;
        n_tsl  = r_tsl;
        n_tsc  = r_tsc;
        n_cnt  = r_cnt;
        n_halt = r_halt;
        n_buf  = r_buf;
        for (int i = 0; i < stt_pkg::MaxResults; i++) res[i] = '0;
        rc     = 2'd0;
        redo   = 1'b0;
        single = stt_pkg::K_END;
        b      = i_item.text_byte;
        nl     = (b == "\n") || (b == "\r");
        adv_line = (b == "\n") ? pos_inc(r_line) : r_line;
        adv_col  = (b == "\n") ? PB'(1) : pos_inc(r_col);

        if (i_take && i_item.byte_present && !r_halt) begin
            unique case (r_mode)
                stt_pkg::M_IDENT: begin
                    if (stt_pkg::is_alpha(b) || stt_pkg::is_digit(b)) begin
                        for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                            if (32'(r_cnt) == i) n_buf[i] = b;
                        n_cnt = len_inc(r_cnt);
                        n_line = adv_line; n_col = adv_col;
                    end else begin
                        res[rc] = mk(word_kind(r_buf, r_cnt), stt_pkg::E_NONE,
                                     r_tsl, r_tsc, r_cnt);
                        rc = rc + 2'd1;
                        redo = 1'b1;
                    end
                end
                stt_pkg::M_NUMBER: begin
                    if (stt_pkg::is_digit(b)) begin
                        n_cnt = len_inc(r_cnt);
                        n_line = adv_line; n_col = adv_col;
                    end else begin
                        res[rc] = mk(stt_pkg::K_NUM, stt_pkg::E_NONE, r_tsl, r_tsc, r_cnt);
                        rc = rc + 2'd1;
                        redo = 1'b1;
                    end
                end
                stt_pkg::M_STRING: begin
                    if (b == "'") begin
                        n_line = adv_line; n_col = adv_col;
                        res[rc] = mk(stt_pkg::K_STR, stt_pkg::E_NONE, r_tsl, r_tsc, r_cnt);
                        rc = rc + 2'd1;
                        n_mode = stt_pkg::M_IDLE;
                    end else if (nl) begin
                        res[rc] = mk(stt_pkg::K_ERROR, stt_pkg::E_STR_NL, r_line, r_col,
                                     LB'(0));
                        rc = rc + 2'd1;
                        n_halt = 1'b1;
                    end else begin
                        n_cnt = len_inc(r_cnt);
                        n_line = adv_line; n_col = adv_col;
                    end
                end
                stt_pkg::M_SLASH: begin
                    if (b == "/") begin
                        n_line = adv_line; n_col = adv_col;
                        n_mode = stt_pkg::M_LINECOM;
                    end else begin
                        res[rc] = mk(stt_pkg::K_DIV, stt_pkg::E_NONE, r_tsl, r_tsc, LB'(1));
                        rc = rc + 2'd1;
                        redo = 1'b1;
                    end
                end
                stt_pkg::M_LINECOM: begin
                    n_line = adv_line; n_col = adv_col;
                    if (nl) n_mode = stt_pkg::M_IDLE;
                end
                stt_pkg::M_BLOCKCOM: begin
                    n_line = adv_line; n_col = adv_col;
                    if (b == "}") n_mode = stt_pkg::M_IDLE;
                end
                stt_pkg::M_COLON: begin
                    if (b == "=") begin
                        n_line = adv_line; n_col = adv_col;
                        res[rc] = mk(stt_pkg::K_ASSIGN, stt_pkg::E_NONE, r_tsl, r_tsc,
                                     LB'(2));
                        rc = rc + 2'd1;
                        n_mode = stt_pkg::M_IDLE;
                    end else begin
                        res[rc] = mk(stt_pkg::K_COLON, stt_pkg::E_NONE, r_tsl, r_tsc,
                                     LB'(1));
                        rc = rc + 2'd1;
                        redo = 1'b1;
                    end
                end
                stt_pkg::M_LESS: begin
                    if (b == "=" || b == ">") begin
                        n_line = adv_line; n_col = adv_col;
                        res[rc] = mk((b == "=") ? stt_pkg::K_LE : stt_pkg::K_NE,
                                     stt_pkg::E_NONE, r_tsl, r_tsc, LB'(2));
                        rc = rc + 2'd1;
                        n_mode = stt_pkg::M_IDLE;
                    end else begin
                        res[rc] = mk(stt_pkg::K_LT, stt_pkg::E_NONE, r_tsl, r_tsc, LB'(1));
                        rc = rc + 2'd1;
                        redo = 1'b1;
                    end
                end
                stt_pkg::M_GREATER: begin
                    if (b == "=") begin
                        n_line = adv_line; n_col = adv_col;
                        res[rc] = mk(stt_pkg::K_GE, stt_pkg::E_NONE, r_tsl, r_tsc, LB'(2));
                        rc = rc + 2'd1;
                        n_mode = stt_pkg::M_IDLE;
                    end else begin
                        res[rc] = mk(stt_pkg::K_GT, stt_pkg::E_NONE, r_tsl, r_tsc, LB'(1));
                        rc = rc + 2'd1;
                        redo = 1'b1;
                    end
                end
                stt_pkg::M_IDLE: redo = 1'b1;
                default: redo = 1'b1;
            endcase

            // byte opens a new token (position not yet advanced on this path)
            if (redo) begin
                n_tsl  = r_line;
                n_tsc  = r_col;
                n_mode = stt_pkg::M_IDLE;
                n_line = adv_line;
                n_col  = adv_col;
                if (stt_pkg::is_alpha(b)) begin
                    n_buf[0] = b;
                    n_cnt    = LB'(1);
                    n_mode   = stt_pkg::M_IDENT;
                end else if (stt_pkg::is_digit(b)) begin
                    n_cnt  = LB'(1);
                    n_mode = stt_pkg::M_NUMBER;
                end else if (b == "'") begin
                    n_cnt  = LB'(0);
                    n_mode = stt_pkg::M_STRING;
                end else if (b == "/") n_mode = stt_pkg::M_SLASH;
                else if (b == "{") n_mode = stt_pkg::M_BLOCKCOM;
                else if (b == ":") n_mode = stt_pkg::M_COLON;
                else if (b == "<") n_mode = stt_pkg::M_LESS;
                else if (b == ">") n_mode = stt_pkg::M_GREATER;
                else if (!(b == " " || b == "\t" || nl)) begin
                    priority case (b)
                        "+":     single = stt_pkg::K_PLUS;
                        "-":     single = stt_pkg::K_MINUS;
                        "*":     single = stt_pkg::K_MULT;
                        "=":     single = stt_pkg::K_EQ;
                        ";":     single = stt_pkg::K_SEMI;
                        ".":     single = stt_pkg::K_DOT;
                        ",":     single = stt_pkg::K_COMMA;
                        "(":     single = stt_pkg::K_LPAREN;
                        ")":     single = stt_pkg::K_RPAREN;
                        default: single = stt_pkg::K_END;
                    endcase
                    if (single != stt_pkg::K_END) begin
                        res[rc] = mk(single, stt_pkg::E_NONE, r_line, r_col, LB'(1));
                    end else begin
                        res[rc] = mk(stt_pkg::K_ERROR, stt_pkg::E_UNKNOWN, adv_line,
                                     adv_col, LB'(0));
                        n_halt = 1'b1;
                    end
                    rc = rc + 2'd1;
                end
            end
        end

        if (i_take && i_item.source_end) begin
            if (!n_halt) begin
                unique case (n_mode)
                    stt_pkg::M_IDENT: begin
                        res[rc] = mk(word_kind(n_buf, n_cnt), stt_pkg::E_NONE,
                                     n_tsl, n_tsc, n_cnt);
                        rc = rc + 2'd1;
                    end
                    stt_pkg::M_NUMBER: begin
                        res[rc] = mk(stt_pkg::K_NUM, stt_pkg::E_NONE, n_tsl, n_tsc, n_cnt);
                        rc = rc + 2'd1;
                    end
                    stt_pkg::M_STRING, stt_pkg::M_BLOCKCOM: begin
                        res[rc] = mk(stt_pkg::K_ERROR,
                                     (n_mode == stt_pkg::M_STRING) ? stt_pkg::E_STR_OPEN
                                                                   : stt_pkg::E_COM_OPEN,
                                     n_line, n_col, LB'(0));
                        rc = rc + 2'd1;
                        n_halt = 1'b1;
                    end
                    stt_pkg::M_SLASH, stt_pkg::M_COLON, stt_pkg::M_LESS,
                    stt_pkg::M_GREATER: begin
                        unique case (n_mode)
                            stt_pkg::M_SLASH: single = stt_pkg::K_DIV;
                            stt_pkg::M_COLON: single = stt_pkg::K_COLON;
                            stt_pkg::M_LESS:  single = stt_pkg::K_LT;
                            default:          single = stt_pkg::K_GT;
                        endcase
                        res[rc] = mk(single, stt_pkg::E_NONE, n_tsl, n_tsc, LB'(1));
                        rc = rc + 2'd1;
                    end
                    default: ;
                endcase
                if (!n_halt) begin
                    res[rc] = mk(stt_pkg::K_END, stt_pkg::E_NONE, n_line, n_col, LB'(0));
                    rc = rc + 2'd1;
                end
            end
            n_mode = stt_pkg::M_IDLE;
            n_line = PB'(1);
            n_col  = PB'(1);
            n_tsl  = PB'(1);
            n_tsc  = PB'(1);
            n_cnt  = LB'(0);
            n_halt = 1'b0;
        end

        if (rc != 2'd0) res[rc - 2'd1].run_last = 1'b1;
    end

    assign o_res     = res;
    assign o_res_cnt = rc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stt_pkg::M_IDLE;
            r_line <= PB'(1);
            r_col  <= PB'(1);
            r_tsl  <= PB'(1);
            r_tsc  <= PB'(1);
            r_cnt  <= LB'(0);
            r_halt <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
            r_tsl  <= n_tsl;
            r_tsc  <= n_tsc;
            r_cnt  <= n_cnt;
            r_halt <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) r_buf <= n_buf;
    end

endmodule

// File: rtl/source_text_tokenizer.sv
// Output: results of an accepted beat are registered in the result queue and leave it
//   in order, one result beat per cycle while the sink is ready.
// Throughput: one input beat per cycle while the 8-entry result queue has room for
//   three results; a beat yields up to three results.
// Reset (synchronous, active low) clears scan state, position counters and the queue;
//   the keyword buffer is left as is.
module source_text_tokenizer #(
    parameter int POSITION_BITS   = stt_pkg::PositionBitsDef,
    parameter int LENGTH_BITS     = stt_pkg::LengthBitsDef,
    parameter int KEYWORD_MAX_LEN = stt_pkg::KeywordMaxDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stt_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output stt_pkg::t_out_item o_out
);
    localparam int AW = stt_pkg::FifoAw;

    stt_pkg::t_out_item res [stt_pkg::MaxResults];
    logic [1:0]         res_cnt;
    logic               take, pop;

    // result queue: small register array, up to three writes per cycle
    stt_pkg::t_out_item r_q [stt_pkg::FifoDepth];
    logic [AW-1:0]      r_wr, r_rd;
    logic [AW:0]        r_count;

    assign o_in_ready  = r_count <= (AW+1)'(stt_pkg::FifoDepth - stt_pkg::MaxResults);
    assign take        = i_in_valid && o_in_ready;
    assign o_out_valid = r_count != '0;
    assign o_out       = r_q[r_rd];
    assign pop         = o_out_valid && i_out_ready;

    // Scanner: state update and result generation for one beat per cycle while the queue has room
    stt_core #(
        .POSITION_BITS  (POSITION_BITS),
        .LENGTH_BITS    (LENGTH_BITS),
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (i_in),
        .o_res    (res),
        .o_res_cnt(res_cnt)
    );

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < stt_pkg::MaxResults; k++)
            if (take && k < 32'(res_cnt)) r_q[r_wr + AW'(k)] <= res[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (take) r_wr <= r_wr + AW'(res_cnt);
            if (pop)  r_rd <= r_rd + AW'(1);
            r_count <= r_count + (take ? (AW+1)'(res_cnt) : '0) - (AW+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(stt_pkg::FifoDepth))
        else $error("result queue overflow");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && res_cnt != 2'd0 |=> o_out_valid)
        else $error("pushed result not visible");

    a_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && r_count == (AW+1)'(1) && !(take && res_cnt != 2'd0) |=> !o_out_valid)
        else $error("queue not empty after last beat drained");

    a_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && res_cnt != 2'd0 |-> res[res_cnt - 2'd1].run_last)
        else $error("last result of a beat lacks run_last");
`endif

endmodule

// File: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Run-wide limits
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned DRAIN_WAIT  = 20;
    localparam logic [15:0] POS_TOP     = 16'hFFFF;
    localparam logic [11:0] LEN_TOP     = 12'hFFF;

    // Idle phases: each beat carries the phase it is driven under
    localparam int PH_STEADY = 0;
    localparam int PH_SRC    = 1;
    localparam int PH_SINK   = 2;
    localparam int PH_BOTH   = 3;

    typedef struct {
        stt_pkg::t_in_item item;
        int                phase;
    } t_pending;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    stt_pkg::t_in_item   in_beat;
    logic                out_valid;
    logic                out_roll;
    logic                out_hold;
    logic                out_ready;
    stt_pkg::t_out_item  out_beat;

    t_pending            byte_queue[$];
    stt_pkg::t_out_item  token_queue[$];

    int         cur_phase;
    int         errors;
    int         beats_in;
    int         tokens_seen;
    int         sources_done;
    int unsigned cycles;
    int         hold_left;
    bit         hold_done;

    assign out_ready = out_roll && !out_hold;

    source_text_tokenizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Scanner predictor: own copy of the scan state, fed with every
    // accepted beat, pushes the tokens it should produce.
    // ------------------------------------------------------------------
    stt_pkg::t_mode      sc_mode;
    logic [15:0]         sc_line;
    logic [15:0]         sc_col;
    logic [15:0]         sc_tok_line;
    logic [15:0]         sc_tok_col;
    logic [11:0]         sc_len;
    logic [7:0]          sc_word[10];
    bit                  sc_halted;
    stt_pkg::t_out_item  sc_batch[$];

    string keyword_text[17] = '{"programa", "var", "inteiro", "logico", "inicio", "fim",
                                "se", "entao", "senao", "enquanto", "faca", "ler",
                                "escrever", "verdadeiro", "falso", "e", "ou"};

    function automatic logic [15:0] pos_inc(input logic [15:0] v);
        return (v != POS_TOP) ? v + 16'd1 : v;
    endfunction

    function automatic logic [11:0] len_inc(input logic [11:0] v);
        return (v != LEN_TOP) ? v + 12'd1 : v;
    endfunction

    function automatic bit letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit numeral(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit line_break(input logic [7:0] b);
        return b == 8'h0A || b == 8'h0D;
    endfunction

    task automatic scan_clear();
        sc_mode     = stt_pkg::M_IDLE;
        sc_line     = 16'd1;
        sc_col      = 16'd1;
        sc_tok_line = 16'd1;
        sc_tok_col  = 16'd1;
        sc_len      = '0;
        sc_halted   = 1'b0;
    endtask

    task automatic scan_move(input logic [7:0] b);
        if (b == 8'h0A) begin
            sc_line = pos_inc(sc_line);
            sc_col  = 16'd1;
        end else begin
            sc_col = pos_inc(sc_col);
        end
    endtask

    task automatic put_token(input logic [5:0] kind, input logic [2:0] code,
                             input logic [15:0] ln, input logic [15:0] col,
                             input logic [11:0] len);
        stt_pkg::t_out_item t;
        t.token_kind   = kind;
        t.error_code   = code;
        t.start_line   = ln;
        t.start_column = col;
        t.token_length = len;
        t.run_last     = 1'b0;
        if (sc_batch.size() < stt_pkg::MaxResults) sc_batch.push_back(t);
    endtask

    task automatic put_lexeme(input logic [5:0] kind, input logic [11:0] len);
        put_token(kind, stt_pkg::E_NONE, sc_tok_line, sc_tok_col, len);
    endtask

    task automatic put_fault(input logic [2:0] code);
        put_token(stt_pkg::K_ERROR, code, sc_line, sc_col, 12'd0);
        sc_halted = 1'b1;
    endtask

    task automatic put_word();
        logic [5:0] kind;
        bit         same;
        kind = stt_pkg::K_ID;
        // a saturated length is never a keyword
        if (sc_len != LEN_TOP && sc_len <= 12'd10) begin
            for (int i = 0; i < 17; i++) begin
                if (kind == stt_pkg::K_ID && keyword_text[i].len() == int'(sc_len)) begin
                    same = 1'b1;
                    for (int j = 0; j < keyword_text[i].len(); j++)
                        if (sc_word[j] != keyword_text[i][j]) same = 1'b0;
                    if (same) kind = stt_pkg::K_KW0 + 6'(i);
                end
            end
        end
        put_lexeme(kind, sc_len);
    endtask

    task automatic scan_start(input logic [7:0] b);
        logic [5:0] kind;
        bit         single;
        single      = 1'b1;
        kind        = stt_pkg::K_END;
        sc_tok_line = sc_line;
        sc_tok_col  = sc_col;
        sc_mode     = stt_pkg::M_IDLE;
        if (b == " " || b == 8'h09 || line_break(b)) begin
            scan_move(b);
        end else if (letter(b)) begin
            sc_word[0] = b;
            sc_len     = 12'd1;
            sc_mode    = stt_pkg::M_IDENT;
            scan_move(b);
        end else if (numeral(b)) begin
            sc_len  = 12'd1;
            sc_mode = stt_pkg::M_NUMBER;
            scan_move(b);
        end else begin
            case (b)
                "'": begin sc_len = '0; sc_mode = stt_pkg::M_STRING; single = 1'b0; end
                "/": begin sc_mode = stt_pkg::M_SLASH;    single = 1'b0; end
                "{": begin sc_mode = stt_pkg::M_BLOCKCOM; single = 1'b0; end
                ":": begin sc_mode = stt_pkg::M_COLON;    single = 1'b0; end
                "<": begin sc_mode = stt_pkg::M_LESS;     single = 1'b0; end
                ">": begin sc_mode = stt_pkg::M_GREATER;  single = 1'b0; end
                "+": kind = stt_pkg::K_PLUS;
                "-": kind = stt_pkg::K_MINUS;
                "*": kind = stt_pkg::K_MULT;
                "=": kind = stt_pkg::K_EQ;
                ";": kind = stt_pkg::K_SEMI;
                ".": kind = stt_pkg::K_DOT;
                ",": kind = stt_pkg::K_COMMA;
                "(": kind = stt_pkg::K_LPAREN;
                ")": kind = stt_pkg::K_RPAREN;
                default: kind = stt_pkg::K_END;
            endcase
            scan_move(b);
            if (single) begin
                // unknown bytes report the position after the byte
                if (kind != stt_pkg::K_END) put_lexeme(kind, 12'd1);
                else put_fault(stt_pkg::E_UNKNOWN);
            end
        end
    endtask

    task automatic scan_byte(input logic [7:0] b);
        bit restart;
        restart = 1'b1;
        case (sc_mode)
            stt_pkg::M_IDENT: begin
                if (letter(b) || numeral(b)) begin
                    if (sc_len < 12'd10) sc_word[sc_len] = b;
                    sc_len  = len_inc(sc_len);
                    scan_move(b);
                    restart = 1'b0;
                end else begin
                    put_word();
                end
            end
            stt_pkg::M_NUMBER: begin
                if (numeral(b)) begin
                    sc_len  = len_inc(sc_len);
                    scan_move(b);
                    restart = 1'b0;
                end else begin
                    put_lexeme(stt_pkg::K_NUM, sc_len);
                end
            end
            stt_pkg::M_STRING: begin
                restart = 1'b0;
                if (b == "'") begin
                    scan_move(b);
                    put_lexeme(stt_pkg::K_STR, sc_len);
                    sc_mode = stt_pkg::M_IDLE;
                end else if (line_break(b)) begin
                    // position before the break is consumed
                    put_fault(stt_pkg::E_STR_NL);
                end else begin
                    sc_len = len_inc(sc_len);
                    scan_move(b);
                end
            end
            stt_pkg::M_SLASH: begin
                if (b == "/") begin
                    scan_move(b);
                    sc_mode = stt_pkg::M_LINECOM;
                    restart = 1'b0;
                end else begin
                    put_lexeme(stt_pkg::K_DIV, 12'd1);
                end
            end
            stt_pkg::M_LINECOM: begin
                scan_move(b);
                if (line_break(b)) sc_mode = stt_pkg::M_IDLE;
                restart = 1'b0;
            end
            stt_pkg::M_BLOCKCOM: begin
                scan_move(b);
                if (b == "}") sc_mode = stt_pkg::M_IDLE;
                restart = 1'b0;
            end
            stt_pkg::M_COLON: begin
                if (b == "=") begin
                    scan_move(b);
                    put_lexeme(stt_pkg::K_ASSIGN, 12'd2);
                    sc_mode = stt_pkg::M_IDLE;
                    restart = 1'b0;
                end else begin
                    put_lexeme(stt_pkg::K_COLON, 12'd1);
                end
            end
            stt_pkg::M_LESS: begin
                if (b == "=" || b == ">") begin
                    scan_move(b);
                    put_lexeme((b == "=") ? stt_pkg::K_LE : stt_pkg::K_NE, 12'd2);
                    sc_mode = stt_pkg::M_IDLE;
                    restart = 1'b0;
                end else begin
                    put_lexeme(stt_pkg::K_LT, 12'd1);
                end
            end
            stt_pkg::M_GREATER: begin
                if (b == "=") begin
                    scan_move(b);
                    put_lexeme(stt_pkg::K_GE, 12'd2);
                    sc_mode = stt_pkg::M_IDLE;
                    restart = 1'b0;
                end else begin
                    put_lexeme(stt_pkg::K_GT, 12'd1);
                end
            end
            default: ;
        endcase
        if (restart) scan_start(b);
    endtask

    task automatic scan_close();
        if (!sc_halted) begin
            case (sc_mode)
                stt_pkg::M_IDENT:    put_word();
                stt_pkg::M_NUMBER:   put_lexeme(stt_pkg::K_NUM, sc_len);
                stt_pkg::M_STRING:   put_fault(stt_pkg::E_STR_OPEN);
                stt_pkg::M_SLASH:    put_lexeme(stt_pkg::K_DIV, 12'd1);
                stt_pkg::M_BLOCKCOM: put_fault(stt_pkg::E_COM_OPEN);
                stt_pkg::M_COLON:    put_lexeme(stt_pkg::K_COLON, 12'd1);
                stt_pkg::M_LESS:     put_lexeme(stt_pkg::K_LT, 12'd1);
                stt_pkg::M_GREATER:  put_lexeme(stt_pkg::K_GT, 12'd1);
                default: ;
            endcase
            if (!sc_halted) put_token(stt_pkg::K_END, stt_pkg::E_NONE, sc_line, sc_col, 12'd0);
        end
    endtask

    // One accepted beat in, its tokens appended to token_queue
    task automatic scan_predict(input stt_pkg::t_in_item it);
        sc_batch.delete();
        if (it.byte_present && !sc_halted) scan_byte(it.text_byte);
        if (it.source_end) begin
            scan_close();
            scan_clear();
            sources_done++;
        end
        if (sc_batch.size() > 0) sc_batch[sc_batch.size() - 1].run_last = 1'b1;
        foreach (sc_batch[i]) token_queue.push_back(sc_batch[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    int build_phase;

    task automatic add_beat(input logic [7:0] b, input bit present, input bit last);
        t_pending p;
        p.item.text_byte    = b;
        p.item.byte_present = present;
        p.item.source_end   = last;
        p.phase             = build_phase;
        byte_queue.push_back(p);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_beat(s[i], 1'b1, 1'b0);
    endtask

    // end mark: either alone or riding on a final byte
    task automatic add_end();
        if ($urandom_range(0, 1)) add_beat(8'($urandom), 1'b0, 1'b1);
        else add_beat(" ", 1'b1, 1'b1);
    endtask

    function automatic logic [7:0] pick_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                    : 8'($urandom_range("A", "Z"));
    endfunction

    // one random lexical piece, mostly well formed
    task automatic add_piece();
        string ops[15] = '{"+", "-", "*", "/", "=", "<>", "<", "<=", ">", ">=",
                           ":=", ";", ".", ",", ":"};
        int    sel;
        int    n;
        sel = $urandom_range(0, 99);
        if (sel < 22) begin
            add_text(keyword_text[$urandom_range(0, 16)]);
        end else if (sel < 38) begin
            n = $urandom_range(1, 12);
            add_beat(pick_letter(), 1'b1, 1'b0);
            for (int i = 1; i < n; i++)
                add_beat($urandom_range(0, 3) ? pick_letter()
                                              : 8'($urandom_range("0", "9")), 1'b1, 1'b0);
        end else if (sel < 48) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) add_beat(8'($urandom_range("0", "9")), 1'b1, 1'b0);
        end else if (sel < 66) begin
            if ($urandom_range(0, 3)) add_text(ops[$urandom_range(0, 14)]);
            else add_text($urandom_range(0, 1) ? "(" : ")");
        end else if (sel < 74) begin
            add_text("'");
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) add_beat(8'($urandom_range(" ", "&")), 1'b1, 1'b0);
            if ($urandom_range(0, 9)) add_text("'");
            else add_beat($urandom_range(0, 1) ? 8'h0A : 8'h0D, 1'b1, 1'b0);
        end else if (sel < 79) begin
            add_text($urandom_range(0, 1) ? "{ a+1\n}" : "// x:=2");
            add_beat($urandom_range(0, 1) ? 8'h0A : 8'h0D, 1'b1, 1'b0);
        end else if (sel < 92) begin
            case ($urandom_range(0, 3))
                0: add_text(" ");
                1: add_beat(8'h09, 1'b1, 1'b0);
                2: add_beat(8'h0A, 1'b1, 1'b0);
                default: add_beat(8'h0D, 1'b1, 1'b0);
            endcase
        end else if (sel < 96) begin
            add_beat(8'($urandom), 1'b0, 1'b0);
        end else begin
            // noise: high bytes or stray punctuation
            add_beat($urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                                          : 8'($urandom), 1'b1, 1'b0);
        end
    endtask

    initial begin
        build_phase = PH_STEADY;
        // directed: operators and lookahead, string with content, end tokens
        add_text("x:=12;a<>b>='q'");
        add_end();
        // unknown byte halts, following input ignored, end emits nothing
        add_text("#+");
        add_beat(8'hFF, 1'b1, 1'b1);
        // newline inside a string
        add_text("'a");
        add_beat(8'h0D, 1'b1, 1'b1);
        // open string, open block comment, open line comment at end
        add_text("'z");
        add_end();
        add_text("{c");
        add_end();
        add_text("//");
        add_end();
        // pending slash at end, empty item on the way
        add_beat(8'h00, 1'b0, 1'b0);
        add_text("/");
        add_end();

        // random sources across the four idle phases
        for (int ph = 0; ph < 4; ph++) begin
            build_phase = ph;
            for (int s = 0; s < 4; s++) begin
                for (int k = 0; k < $urandom_range(3, 9); k++) begin
                    add_piece();
                    if ($urandom_range(0, 2) == 0) add_text(" ");
                end
                add_end();
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: one beat offered at a time, held until accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit       taken;
        bit       idle;
        t_pending p;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_beat  <= '0;
        end else begin
            taken = in_valid && in_ready;
            if (taken) begin
                scan_predict(in_beat);
                beats_in++;
            end
            if (!in_valid || taken) begin
                if (byte_queue.size() > 0) begin
                    cur_phase = byte_queue[0].phase;
                    idle = (cur_phase == PH_SRC) ? ($urandom_range(0, 99) < 46) :
                           (cur_phase == PH_BOTH) ? ($urandom_range(0, 99) < 17) : 1'b0;
                    if (!idle) begin
                        p = byte_queue.pop_front();
                        in_valid <= 1'b1;
                        in_beat  <= p.item;
                    end else begin
                        in_valid <= 1'b0;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every accepted token beat against the oldest one due
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        stt_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_roll <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                tokens_seen++;
                if (token_queue.size() == 0) begin
                    $display("%0t: unexpected token beat %p", $time, out_beat);
                    errors++;
                end else begin
                    want = token_queue.pop_front();
                    if (out_beat.token_kind !== want.token_kind) begin
                        $display("%0t: token_kind expected %0d actual %0d",
                                 $time, want.token_kind, out_beat.token_kind);
                        errors++;
                    end
                    if (out_beat.error_code !== want.error_code) begin
                        $display("%0t: error_code expected %0d actual %0d",
                                 $time, want.error_code, out_beat.error_code);
                        errors++;
                    end
                    if (out_beat.start_line !== want.start_line) begin
                        $display("%0t: start_line expected %0d actual %0d",
                                 $time, want.start_line, out_beat.start_line);
                        errors++;
                    end
                    if (out_beat.start_column !== want.start_column) begin
                        $display("%0t: start_column expected %0d actual %0d",
                                 $time, want.start_column, out_beat.start_column);
                        errors++;
                    end
                    if (out_beat.token_length !== want.token_length) begin
                        $display("%0t: token_length expected %0d actual %0d",
                                 $time, want.token_length, out_beat.token_length);
                        errors++;
                    end
                    if (out_beat.run_last !== want.run_last) begin
                        $display("%0t: run_last expected %0d actual %0d",
                                 $time, want.run_last, out_beat.run_last);
                        errors++;
                    end
                end
            end
            out_roll <= (cur_phase == PH_SINK) ? ($urandom_range(0, 99) >= 46) :
                        (cur_phase == PH_BOTH) ? ($urandom_range(0, 99) >= 17) : 1'b1;
        end
    end

    // Long sink hold-off once, mid-run, while the source keeps pushing
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_hold  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_hold  <= (hold_left > 1);
        end else if (!hold_done && beats_in >= 120) begin
            hold_done <= 1'b1;
            hold_left <= 80;
            out_hold  <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        errors       = 0;
        beats_in     = 0;
        tokens_seen  = 0;
        sources_done = 0;
        cycles       = 0;
        cur_phase    = PH_STEADY;
        in_valid     = 1'b0;
        in_beat      = '0;
        out_roll     = 1'b0;
        out_hold     = 1'b0;
        scan_clear();
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // wait for all stimulus to be accepted and all tokens drained
        do @(posedge i_clk);
        while (byte_queue.size() > 0 || in_valid || token_queue.size() > 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (token_queue.size() > 0) begin
            $display("%0t: %0d tokens never arrived", $time, token_queue.size());
            errors++;
        end
        $display("Scanned %0d beats in %0d sources, checked %0d tokens, %0d mismatches",
                 beats_in, sources_done, tokens_seen, errors);
        $display("Covered directed lexical corner cases, all idle phases and a long sink hold-off");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
